/* hdl/rdb_pkg.sv */
// Shared types, register indexes and switch patterns for the RC dead-band bridge driver.
// No dependencies; used by every module in hdl/.
package rdb_pkg;

  localparam int PulseW = 16;
  localparam int CountW = 8;
  localparam int DriveW = 6;
  localparam int CfgIdxW = 2;

  // Switch enable bits of the drive word.
  localparam logic [DriveW-1:0] DrvAh = 6'h01;
  localparam logic [DriveW-1:0] DrvAl = 6'h02;
  localparam logic [DriveW-1:0] DrvBh = 6'h04;
  localparam logic [DriveW-1:0] DrvBl = 6'h08;
  localparam logic [DriveW-1:0] DrvCh = 6'h10;
  localparam logic [DriveW-1:0] DrvCl = 6'h20;
  localparam logic [DriveW-1:0] DrvOff = 6'h00;

  localparam logic [PulseW-1:0] CentreLowReset = 16'd1450;
  localparam logic [PulseW-1:0] CentreHighReset = 16'd1550;
  localparam logic [CountW-1:0] ArmFramesReset = 8'd15;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTRE_LOW  = 2'd0,
    REG_CENTRE_HIGH = 2'd1,
    REG_ARM_FRAMES  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [PulseW-1:0] centre_low;
    logic [PulseW-1:0] centre_high;
    logic [CountW-1:0] arm_frames;
  } cfg_t;

  typedef struct packed {
    logic              is_armed;
    logic [CountW-1:0] centre_count;
    logic              powered;
    logic              direction_fwd;
    logic [1:0]        phase;
  } state_t;

  typedef struct packed {
    logic [DriveW-1:0] drive;
    logic              brake_pulse;
    logic              arm_event;
    logic              armed;
  } result_t;

  // Four-phase square wave: drive, off, reverse drive, off.
  function automatic logic [DriveW-1:0] bridge_pattern(input logic fwd,
                                                       input logic [1:0] ph);
    logic [DriveW-1:0] pat;
    unique case (ph)
      2'd0:    pat = fwd ? (DrvAh | DrvBl) : (DrvCh | DrvBl);
      2'd2:    pat = fwd ? (DrvAl | DrvBh) : (DrvCl | DrvBh);
      default: pat = DrvOff;
    endcase
    return pat;
  endfunction

endpackage

/* hdl/rdb_cfg.sv */
// Configuration registers of the RC dead-band bridge driver.
// Depends on rdb_pkg.
module rdb_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rdb_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rdb_pkg::PulseW-1:0]    cfg_data,
  output rdb_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.centre_low  <= rdb_pkg::CentreLowReset;
      cfg.centre_high <= rdb_pkg::CentreHighReset;
      cfg.arm_frames  <= rdb_pkg::ArmFramesReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rdb_pkg::REG_CENTRE_LOW:  cfg.centre_low  <= cfg_data;
        rdb_pkg::REG_CENTRE_HIGH: cfg.centre_high <= cfg_data;
        rdb_pkg::REG_ARM_FRAMES:  cfg.arm_frames  <= cfg_data[rdb_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hdl/rdb_step.sv */
// Combinational step logic: band compares, arming count and bridge phase update.
// Depends on rdb_pkg.
module rdb_step (
  input  logic [rdb_pkg::PulseW-1:0] pulse_width,
  input  rdb_pkg::cfg_t              cfg,
  input  rdb_pkg::state_t            state,
  output rdb_pkg::state_t            state_next,
  output rdb_pkg::result_t           result
);

  logic                        above;
  logic                        below;
  logic [rdb_pkg::CountW-1:0]  need;
  logic [rdb_pkg::CountW-1:0]  count_inc;

  assign above     = pulse_width > cfg.centre_high;
  assign below     = pulse_width < cfg.centre_low;
  assign need      = (cfg.arm_frames == '0) ? rdb_pkg::CountW'(1) : cfg.arm_frames;
  assign count_inc = state.centre_count + rdb_pkg::CountW'(1);

  always_comb begin
    state_next         = state;
    result.drive       = rdb_pkg::DrvOff;
    result.brake_pulse = 1'b0;
    result.arm_event   = 1'b0;
    if (!state.is_armed) begin
      if (!above && !below) begin
        if (count_inc >= need) begin
          state_next.is_armed     = 1'b1;
          state_next.centre_count = '0;
          result.arm_event        = 1'b1;
        end else begin
          state_next.centre_count = count_inc;
        end
      end else begin
        state_next.centre_count = '0;
      end
    end else if (above || below) begin
      // Above-band is tested first, so an inverted band drives forward.
      state_next.direction_fwd = above;
      state_next.powered       = 1'b1;
      state_next.phase         = state.phase + 2'd1;
      result.drive             = rdb_pkg::bridge_pattern(above, state.phase);
    end else if (state.powered) begin
      state_next.powered = 1'b0;
      result.brake_pulse = 1'b1;
    end
    result.armed = state_next.is_armed;
  end

endmodule

/* hdl/rc_deadband_bridge_square_wave.sv */
// Top level of the RC dead-band H-bridge square-wave driver.
// Depends on rdb_pkg, rdb_cfg and rdb_step.
//
// Each accepted word is one receiver pulse width and one step period; it yields
// exactly one result word, valid in the following cycle. A word is taken in
// every cycle the result register is empty or being read, so the sustained
// rate is one word per clock while out_ready holds, set by the single result
// register behind one level of compare and phase logic. Configuration writes
// take effect at the next clock edge and should be made while no word is in flight.
module rc_deadband_bridge_square_wave (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rdb_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [rdb_pkg::PulseW-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rdb_pkg::PulseW-1:0]         pulse_width,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rdb_pkg::DriveW-1:0]         drive,
  output logic                               brake_pulse,
  output logic                               arm_event,
  output logic                               armed
);

  rdb_pkg::cfg_t    cfg;
  rdb_pkg::state_t  state;
  rdb_pkg::state_t  state_next;
  rdb_pkg::result_t result;
  rdb_pkg::result_t result_reg;
  logic             accept;

  rdb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rdb_step u_step (
    .pulse_width (pulse_width),
    .cfg         (cfg),
    .state       (state),
    .state_next  (state_next),
    .result      (result)
  );

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_reg <= result;
    end
  end

  assign drive       = result_reg.drive;
  assign brake_pulse = result_reg.brake_pulse;
  assign arm_event   = result_reg.arm_event;
  assign armed       = result_reg.armed;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_arm_is_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && arm_event |-> armed && drive == rdb_pkg::DrvOff && !brake_pulse)
    else $error("arming step drove the bridge");

  a_brake_is_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && brake_pulse |-> armed && drive == rdb_pkg::DrvOff)
    else $error("brake step with switches on");

  a_armed_sticks: assert property (@(posedge clk) disable iff (rst)
    state.is_armed |=> state.is_armed)
    else $error("armed state dropped without reset");

endmodule
